// ----- rtl/hashed_credential_table_assert.svh -----
// Assertion macros for the credential table: clocked checks with and without reset gating.
`ifndef HASHED_CREDENTIAL_TABLE_ASSERT_SVH
`define HASHED_CREDENTIAL_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define HCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Check on every clock edge, reset included.
`define HCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define HCT_ASSERT(lbl, prop, msg)
`define HCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/hct_pkg.sv -----
// Shared types and constants of the hashed credential table.
`timescale 1ns / 1ps
package hct_pkg;

    localparam int ENTRIES_DEF    = 8;
    localparam int NAME_BYTES_DEF = 24;

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_AUTH = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic PART_NAME = 1'b0;
    localparam logic PART_PASS = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic       part;
        logic [7:0] char_byte;
        logic       new_admin;
        logic [2:0] entry_index;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [3:0]  entry_count;
        logic [31:0] entry_hash;
        logic        entry_admin;
    } result_t;

    // One name character handed to the name store.
    typedef struct packed {
        logic       take;
        logic       restart;
        logic [7:0] ch;
    } name_cmd_t;

endpackage

// ----- rtl/hct_name_cam.sv -----
// Name store: one row per character position, compared across all entries in parallel.
`timescale 1ns / 1ps
module hct_name_cam #(
    parameter int  ENTRIES    = hct_pkg::ENTRIES_DEF,
    parameter int  NAME_BYTES = hct_pkg::NAME_BYTES_DEF,
    localparam int CNT_W      = $clog2(ENTRIES + 1),
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hct_pkg::name_cmd_t cmd,
    input  logic [CNT_W-1:0]  count,
    output logic              found,
    output logic [IDX_W-1:0]  first_idx
);
    import hct_pkg::*;

    localparam int POS_W = $clog2(NAME_BYTES + 1);
    localparam int ROW_W = $clog2(NAME_BYTES);

    logic [ENTRIES-1:0][7:0] name_mem [NAME_BYTES];
    logic [ENTRIES-1:0][7:0] rd_reg;

    logic [POS_W-1:0]   pos_reg, pos_next, p_eff;
    logic               in_range, mem_we;
    logic [ROW_W-1:0]   row;
    logic [7:0]         wbyte;
    logic [IDX_W-1:0]   slot;

    logic               cmp_valid_reg, cmp_restart_reg, cmp_over_reg;
    logic [7:0]         cmp_ch_reg;
    logic [ENTRIES-1:0] flags_reg, flags_next, mask, neq, hit;

    always_comb
    begin
        p_eff    = cmd.restart ? '0 : pos_reg;
        in_range = (p_eff < POS_W'(NAME_BYTES));
        row      = p_eff[ROW_W-1:0];
        slot     = count[IDX_W-1:0];
        // truncate: a byte written at the last position is always the terminator
        wbyte    = (p_eff == POS_W'(NAME_BYTES - 1)) ? 8'h00 : cmd.ch;
        mem_we   = cmd.take && in_range && (count < CNT_W'(ENTRIES));
        pos_next = pos_reg;
        if (cmd.take)
        begin
            if (in_range && (cmd.ch != 8'h00))
                pos_next = p_eff + POS_W'(1);
            else
                pos_next = p_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            name_mem[row][slot] <= wbyte;
        if (cmd.take && in_range)
            rd_reg <= name_mem[row];
        cmp_ch_reg <= cmd.ch;
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            mask[i] = (CNT_W'(i) < count);
            neq[i]  = (rd_reg[i] != cmp_ch_reg);
        end
        flags_next = flags_reg;
        if (cmp_valid_reg)
        begin
            if (cmp_over_reg)
                flags_next = '0;
            else
                flags_next = (cmp_restart_reg ? '1 : flags_reg) & ~(mask & neq);
        end
        hit       = flags_reg & mask;
        found     = |hit;
        first_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit[i])
                first_idx = IDX_W'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_restart_reg <= 1'b0;
            cmp_over_reg    <= 1'b0;
            flags_reg       <= '1;
        end
        else
        begin
            pos_reg         <= pos_next;
            cmp_valid_reg   <= cmd.take;
            cmp_restart_reg <= cmd.restart;
            cmp_over_reg    <= !in_range;
            flags_reg       <= flags_next;
        end
    end

endmodule

// ----- rtl/hashed_credential_table.sv -----
// Top level of the hashed credential table: request sequencer, hash store and result register.
`timescale 1ns / 1ps
`include "hashed_credential_table_assert.svh"
// Usage
//   Input words arrive on in_valid / in_stall / in_word; a word is taken on a rising
//   edge with in_valid high and in_stall low. Result words leave on out_valid /
//   out_stall / out_word in the same way. cfg_we with cfg_wdata sets store_enabled.
//   An add or authenticate request is a stream of words: name characters, a NUL,
//   password characters, a NUL. Name and password characters are taken one per
//   cycle while in_stall is low; each name character reads one row of the name
//   memory and is compared against all entries in the following cycle. The
//   password hash uses one constant multiply per character.
//   The closing password NUL goes to S_LOOKUP (pick the first matching entry,
//   read its hash), then S_DECIDE (compare, load the result register), with
//   in_stall high in both. A read word reads the hash memory as it is taken, then
//   loads the result in S_READ. A result is visible the cycle after it is loaded.
//   While out_stall holds a result, a further result waits in its state and
//   in_stall stays high; words that give no result keep flowing.
//   Reset clears the account count, the request state and store_enabled; the
//   name and hash memories are not cleared.
module hashed_credential_table #(
    parameter int ENTRIES    = hct_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = hct_pkg::NAME_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  hct_pkg::item_t   in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output hct_pkg::result_t out_word,
    input  logic             cfg_we,
    input  logic             cfg_wdata
);
    import hct_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

    typedef enum logic [3:0] {
        S_RUN    = 4'b0001,
        S_READ   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_NAME = 3'b010,
        PH_PASS = 3'b100
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [31:0] hash_reg, hash_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic       enabled_reg;
    logic [1:0] end_op_reg, end_op_next;
    logic       end_adm_reg, end_adm_next;
    logic       add_ok_reg, add_ok_next;
    logic       found_reg, found_next;
    logic [2:0] read_idx_reg, read_idx_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_word_reg, out_word_next;
    logic [IDX_W-1:0] raddr_reg, raddr_next;

    // hash store: {hash, admin} per entry
    logic [32:0] hash_mem [ENTRIES];
    logic [32:0] hash_rd_reg;
    logic        hash_we;
    logic        add_ok;

    logic        accept, slot_free, found;
    logic [IDX_W-1:0] first_idx;
    name_cmd_t   cmd;

    hct_name_cam #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) u_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .count     (count_reg),
        .found     (found),
        .first_idx (first_idx)
    );

    // Only the streaming state takes input words.
    assign in_stall  = (state_reg != S_RUN);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        hash_next      = hash_reg;
        count_next     = count_reg;
        end_op_next    = end_op_reg;
        end_adm_next   = end_adm_reg;
        add_ok_next    = add_ok_reg;
        found_next     = found_reg;
        read_idx_next  = read_idx_reg;
        raddr_next     = raddr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        cmd            = '0;
        hash_we        = 1'b0;
        add_ok         = enabled_reg && (count_reg < CNT_W'(ENTRIES)) && !found;

        case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    case (in_word.op)
                        OP_READ:
                        begin
                            read_idx_next = in_word.entry_index;
                            raddr_next    = IDX_W'(in_word.entry_index);
                            state_next    = S_READ;
                        end
                        OP_ADD, OP_AUTH:
                        begin
                            if (in_word.part == PART_NAME)
                            begin
                                // a name character outside the name phase opens a new request
                                cmd.take    = 1'b1;
                                cmd.restart = (phase_reg != PH_NAME);
                                cmd.ch      = in_word.char_byte;
                                if (phase_reg != PH_NAME)
                                    hash_next = FNV_BASIS;
                                phase_next = (in_word.char_byte == 8'h00) ? PH_PASS : PH_NAME;
                            end
                            else if (phase_reg == PH_PASS)
                            begin
                                if (in_word.char_byte != 8'h00)
                                    hash_next = (hash_reg ^ {24'h0, in_word.char_byte})
                                                * FNV_PRIME;
                                else
                                begin
                                    end_op_next  = in_word.op;
                                    end_adm_next = in_word.new_admin;
                                    state_next   = S_LOOKUP;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOOKUP:
            begin
                // match flags are final here; fetch the first match's hash
                raddr_next  = first_idx;
                found_next  = found;
                add_ok_next = add_ok;
                if ((end_op_reg == OP_ADD) && add_ok)
                begin
                    hash_we    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.ok         = (end_op_reg == OP_ADD) ? add_ok_reg :
                                               (enabled_reg && found_reg &&
                                                (hash_rd_reg[32:1] == hash_reg));
                    out_word_next.entry_count = 4'(count_reg);
                    out_word_next.entry_hash  = '0;
                    out_word_next.entry_admin = 1'b0;
                    hash_next                 = FNV_BASIS;
                    phase_next                = PH_IDLE;
                    state_next                = S_RUN;
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.ok          = (CMP_W'(read_idx_reg) < CMP_W'(count_reg));
                    out_word_next.entry_count = 4'(count_reg);
                    out_word_next.entry_hash  = out_word_next.ok ? hash_rd_reg[32:1] : '0;
                    out_word_next.entry_admin = out_word_next.ok && hash_rd_reg[0];
                    state_next                = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hash_we)
            hash_mem[count_reg[IDX_W-1:0]] <= {hash_reg, end_adm_reg};
        hash_rd_reg  <= hash_mem[raddr_next];
        raddr_reg    <= raddr_next;
        end_op_reg   <= end_op_next;
        end_adm_reg  <= end_adm_next;
        add_ok_reg   <= add_ok_next;
        found_reg    <= found_next;
        read_idx_reg <= read_idx_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            phase_reg     <= PH_IDLE;
            hash_reg      <= FNV_BASIS;
            count_reg     <= '0;
            enabled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                enabled_reg <= cfg_wdata;
        end
    end

    `HCT_ASSERT(a_count_bound, count_reg <= CNT_W'(ENTRIES), "account count above capacity")
    `HCT_ASSERT(a_count_only_on_add, state_reg != S_LOOKUP |=> $stable(count_reg), "count moved outside lookup")
    `HCT_ASSERT(a_lookup_then_decide, state_reg == S_LOOKUP |=> state_reg == S_DECIDE, "lookup not followed by decide")
    `HCT_ASSERT(a_read_taken, in_valid && !in_stall && in_word.op == OP_READ |=> state_reg == S_READ, "read word not serviced")

endmodule

// ----- tb/sv/credential_scoreboard_pkg.sv -----
// Scoreboard class for the credential table: account predictor and result queue.
`timescale 1ns / 1ps
package credential_scoreboard_pkg;

    localparam int ACCOUNTS = hct_pkg::ENTRIES_DEF;
    localparam int NAME_LEN = hct_pkg::NAME_BYTES_DEF;

    // The one op code that the package leaves unnamed.
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef enum logic [1:0] {
        REQ_IDLE,
        REQ_NAME,
        REQ_PASS
    } req_phase_e;

    class credential_scoreboard;
        logic                enabled;
        int unsigned         accounts;
        logic [7:0]          names [ACCOUNTS][NAME_LEN];
        logic [31:0]         hashes [ACCOUNTS];
        logic                admins [ACCOUNTS];
        logic [ACCOUNTS-1:0] flags;
        int unsigned         pos;
        logic [31:0]         digest;
        req_phase_e          phase;
        hct_pkg::result_t    awaited [$];
        int unsigned         errors;
        int unsigned         checked;
        int unsigned         stored;
        int unsigned         granted;
        int unsigned         refused;
        int unsigned         reads;

        function new();
            enabled  = 1'b0;
            accounts = 0;
            phase    = REQ_IDLE;
            for (int i = 0; i < ACCOUNTS; i++)
            begin
                hashes[i] = '0;
                admins[i] = 1'b0;
                for (int j = 0; j < NAME_LEN; j++)
                    names[i][j] = '0;
            end
            restart_request();
        endfunction

        function void restart_request();
            flags  = '1;
            pos    = 0;
            digest = hct_pkg::FNV_BASIS;
        endfunction

        function void take_name_char(logic [7:0] c);
            if (pos < NAME_LEN)
            begin
                for (int i = 0; i < ACCOUNTS; i++)
                    if (i < accounts && names[i][pos] != c)
                        flags[i] = 1'b0;
                if (accounts < ACCOUNTS)
                    names[accounts][pos] = (pos < NAME_LEN - 1) ? c : 8'h00;
                if (c != 8'h00)
                    pos++;
            end
            else
            begin
                flags = '0;
            end
        endfunction

        function int lowest_match();
            for (int i = 0; i < ACCOUNTS; i++)
                if (i < accounts && flags[i])
                    return i;
            return -1;
        endfunction

        // Work out what one accepted word leaves behind, if anything.
        function void note_word(hct_pkg::item_t w);
            hct_pkg::result_t r;
            int hit;
            r = '0;
            if (w.op == OP_NONE)
                return;
            if (w.op == hct_pkg::OP_READ)
            begin
                r.entry_count = 4'(accounts);
                if (int'(w.entry_index) < accounts)
                begin
                    r.ok          = 1'b1;
                    r.entry_hash  = hashes[w.entry_index];
                    r.entry_admin = admins[w.entry_index];
                end
                awaited.push_back(r);
                reads++;
                return;
            end
            if (w.part == hct_pkg::PART_NAME)
            begin
                if (phase != REQ_NAME)
                    restart_request();
                phase = REQ_NAME;
                take_name_char(w.char_byte);
                if (w.char_byte == 8'h00)
                    phase = REQ_PASS;
                return;
            end
            if (phase != REQ_PASS)
                return;
            if (w.char_byte != 8'h00)
            begin
                digest = (digest ^ {24'h0, w.char_byte}) * hct_pkg::FNV_PRIME;
                return;
            end
            hit = lowest_match();
            if (w.op == hct_pkg::OP_ADD)
            begin
                r.ok = enabled && accounts < ACCOUNTS && hit < 0;
                if (r.ok)
                begin
                    hashes[accounts] = digest;
                    admins[accounts] = w.new_admin;
                    accounts++;
                    stored++;
                end
            end
            else
            begin
                r.ok = enabled && hit >= 0 && hashes[hit] == digest;
                if (r.ok)
                    granted++;
            end
            if (!r.ok)
                refused++;
            restart_request();
            phase         = REQ_IDLE;
            r.entry_count = 4'(accounts);
            awaited.push_back(r);
        endfunction

        function void check(hct_pkg::result_t got);
            hct_pkg::result_t want;
            if (awaited.size() == 0)
            begin
                $error("result with nothing awaited: ok=%0d count=%0d hash=%h admin=%0d",
                       got.ok, got.entry_count, got.entry_hash, got.entry_admin);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d, got %0d", want.ok, got.ok);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                errors++;
            end
            if (got.entry_hash !== want.entry_hash)
            begin
                $error("entry_hash: expected %h, got %h", want.entry_hash, got.entry_hash);
                errors++;
            end
            if (got.entry_admin !== want.entry_admin)
            begin
                $error("entry_admin: expected %0d, got %0d", want.entry_admin, got.entry_admin);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_hashed_credential_table.sv -----
// Testbench top for the credential table: directed and random requests against a scoreboard.
`timescale 1ns / 1ps
module tb_hashed_credential_table;
    import credential_scoreboard_pkg::*;

    localparam int POOL           = 8;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    hct_pkg::item_t   in_word = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    hct_pkg::result_t out_word;
    logic             cfg_we = 1'b0;
    logic             cfg_wdata = 1'b0;

    credential_scoreboard sb;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned words_sent = 0;
    int unsigned quiet_cycles = 0;

    // Account pool: a handful of names and passwords reused so that lookups hit.
    logic [7:0] pool_name [POOL][32];
    int         pool_name_n [POOL];
    logic [7:0] pool_pw [POOL][8];
    int         pool_pw_n [POOL];

    // The request about to be sent.
    logic [7:0] name_buf [32];
    int         name_n;
    logic [7:0] pw_buf [8];
    int         pw_n;

    hashed_credential_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure: redraw at every falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Check every result word as it is taken.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check(out_word);

    // Watchdog: count cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: %0d cycles without a word moving", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic hct_pkg::item_t make_word(logic [1:0] op, logic part, logic [7:0] ch,
                                                 logic adm, logic [2:0] idx);
        hct_pkg::item_t w;
        w.op          = op;
        w.part        = part;
        w.char_byte   = ch;
        w.new_admin   = adm;
        w.entry_index = idx;
        return w;
    endfunction

    // Offer one word, optionally after a random gap, and hold it until taken.
    task automatic send_word(input hct_pkg::item_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(w);
        words_sent++;
    endtask

    // A read carries junk in every field it does not use.
    task automatic send_read(input logic [2:0] idx);
        send_word(make_word(hct_pkg::OP_READ, 1'($urandom_range(1)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), idx));
    endtask

    // One character of a request. The op on it is noise: only the closing word decides.
    // Now and then slip a read in between; it must leave the request alone.
    task automatic send_char(input logic part, input logic [7:0] ch);
        send_word(make_word(($urandom_range(1) != 0) ? hct_pkg::OP_AUTH : hct_pkg::OP_ADD,
                            part, ch, 1'($urandom_range(1)), 3'($urandom_range(7))));
        if ($urandom_range(99) < 4)
            send_read(3'($urandom_range(7)));
    endtask

    // Send name_buf and pw_buf as one request; drop the closing word to leave it open.
    task automatic send_request(input logic [1:0] op_end, input logic adm, input bit close);
        for (int i = 0; i < name_n; i++)
            send_char(hct_pkg::PART_NAME, name_buf[i]);
        send_char(hct_pkg::PART_NAME, 8'h00);
        for (int i = 0; i < pw_n; i++)
            send_char(hct_pkg::PART_PASS, pw_buf[i]);
        if (close)
            send_word(make_word(op_end, hct_pkg::PART_PASS, 8'h00, adm, 3'($urandom_range(7))));
    endtask

    // Load a pool account, with its own password or a made-up one.
    task automatic load_account(input int k, input bit right_pw);
        name_n = pool_name_n[k];
        for (int i = 0; i < name_n; i++)
            name_buf[i] = pool_name[k][i];
        if (right_pw)
        begin
            pw_n = pool_pw_n[k];
            for (int i = 0; i < pw_n; i++)
                pw_buf[i] = pool_pw[k][i];
        end
        else
        begin
            pw_n = 1 + $urandom_range(3);
            for (int i = 0; i < pw_n; i++)
                pw_buf[i] = 8'($urandom_range(255, 1));
        end
    endtask

    // Drop valid, let every awaited result arrive, then give the block time to go quiet.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_store_enabled(input logic v);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.enabled = v;
    endtask

    task automatic random_request();
        int kind;
        int k;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            send_read(3'($urandom_range(7)));
        end
        else if (kind < 16)
        begin
            // Noise: an op with no meaning, a stray password character, or an open request.
            case ($urandom_range(2))
                0: send_word(make_word(OP_NONE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                                       1'($urandom_range(1)), 3'($urandom_range(7))));
                1: send_char(hct_pkg::PART_PASS, 8'($urandom_range(255)));
                default:
                begin
                    load_account($urandom_range(POOL - 1), 1'($urandom_range(1)));
                    send_request(hct_pkg::OP_ADD, 1'b0, 1'b0);
                end
            endcase
        end
        else
        begin
            k = $urandom_range(POOL - 1);
            load_account(k, $urandom_range(3) != 0);
            if (kind < 22)
            begin
                // Fresh name that is most likely not stored yet.
                name_n = 1 + $urandom_range(7);
                for (int i = 0; i < name_n; i++)
                    name_buf[i] = 8'($urandom_range(255, 1));
            end
            send_request((kind < 45) ? hct_pkg::OP_ADD : hct_pkg::OP_AUTH,
                         1'($urandom_range(1)), 1'b1);
        end
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall, input logic en,
                             input int unsigned words);
        int unsigned start;
        set_store_enabled(en);
        send_idle_pct = idle;
        stall_pct     = stall;
        start         = words_sent;
        while (words_sent - start < words)
            random_request();
    endtask

    initial
    begin
        sb = new();

        // Pool layout: 0 is the empty account; 1 has a name of exactly the longest
        // storable length; 2 and 3 are longer names sharing that prefix, so they are
        // stored cut down to the same name; 4 carries extreme characters.
        for (int k = 0; k < POOL; k++)
        begin
            pool_name_n[k] = 1 + $urandom_range(5);
            for (int i = 0; i < 32; i++)
                pool_name[k][i] = 8'($urandom_range(255, 1));
            pool_pw_n[k] = 1 + $urandom_range(7);
            for (int i = 0; i < 8; i++)
                pool_pw[k][i] = 8'($urandom_range(255, 1));
        end
        pool_name_n[0] = 0;
        pool_pw_n[0]   = 0;
        pool_name_n[1] = NAME_LEN - 1;
        pool_name_n[2] = NAME_LEN + 3;
        pool_name_n[3] = NAME_LEN;
        for (int i = 0; i < NAME_LEN - 1; i++)
        begin
            pool_name[2][i] = pool_name[1][i];
            pool_name[3][i] = pool_name[1][i];
        end
        // The short form shares the password of the higher duplicate: only the lowest
        // matching entry may be used, so this login must be refused.
        pool_pw_n[1] = pool_pw_n[3];
        for (int i = 0; i < 8; i++)
            pool_pw[1][i] = pool_pw[3][i];
        pool_name_n[4] = 3;
        pool_name[4][0] = 8'hFF;
        pool_name[4][1] = 8'h01;
        pool_name[4][2] = 8'h80;
        pool_pw_n[4]   = 3;
        pool_pw[4][0]  = 8'hFF;
        pool_pw[4][1]  = 8'h7F;
        pool_pw[4][2]  = 8'h01;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Store disabled out of reset: add and login refused, reads still answer.
        load_account(4, 1'b1);
        send_request(hct_pkg::OP_ADD, 1'b1, 1'b1);
        send_request(hct_pkg::OP_AUTH, 1'b0, 1'b1);
        send_read(3'd0);

        set_store_enabled(1'b1);
        send_request(hct_pkg::OP_ADD, 1'b1, 1'b1);
        send_request(hct_pkg::OP_ADD, 1'b0, 1'b1);
        send_request(hct_pkg::OP_AUTH, 1'b0, 1'b1);
        load_account(4, 1'b0);
        send_request(hct_pkg::OP_AUTH, 1'b0, 1'b1);

        // Over-long names: both stored truncated, and neither ever matches again.
        load_account(2, 1'b1);
        send_request(hct_pkg::OP_ADD, 1'b0, 1'b1);
        load_account(3, 1'b1);
        send_request(hct_pkg::OP_ADD, 1'b1, 1'b1);
        load_account(2, 1'b1);
        send_request(hct_pkg::OP_AUTH, 1'b0, 1'b1);
        // The exact-length name now finds two equal entries.
        load_account(1, 1'b1);
        send_request(hct_pkg::OP_AUTH, 1'b0, 1'b1);
        send_request(hct_pkg::OP_ADD, 1'b0, 1'b1);

        // Empty name, empty password.
        load_account(0, 1'b1);
        send_request(hct_pkg::OP_ADD, 1'b1, 1'b1);
        send_read(3'd3);
        send_read(3'd0);
        send_read(3'd7);

        // Ignored words, and a name character arriving mid-password.
        send_word(make_word(OP_NONE, hct_pkg::PART_PASS, 8'h00, 1'b1, 3'd7));
        send_char(hct_pkg::PART_PASS, 8'h55);
        load_account(5, 1'b1);
        send_request(hct_pkg::OP_AUTH, 1'b0, 1'b0);
        send_request(hct_pkg::OP_ADD, 1'b0, 1'b1);

        run_phase(0, 0, 1'b1, 100);
        run_phase(45, 0, 1'b1, 100);
        run_phase(0, 45, 1'b0, 70);
        run_phase(31, 31, 1'b1, 100);
        wait_drained();

        $display("%0d words sent, %0d results checked, %0d mismatches",
                 words_sent, sb.checked, sb.errors);
        $display("accounts stored %0d (final count %0d), logins granted %0d, refusals %0d, reads %0d",
                 sb.stored, sb.accounts, sb.granted, sb.refused, sb.reads);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- hashed_credential_table.f -----
+incdir+rtl
rtl/hct_pkg.sv
rtl/hct_name_cam.sv
rtl/hashed_credential_table.sv
tb/sv/credential_scoreboard_pkg.sv
tb/sv/tb_hashed_credential_table.sv
